### hdl/ds22_pkg.sv
// Shared types, register indexes and arithmetic helpers for the 2x2 downsampler.
`timescale 1ns / 1ps
`default_nettype none

package ds22_pkg;

  // Field widths fixed by the pixel and register formats.
  localparam int PIXEL_W     = 24;
  localparam int INDEX_W     = 22;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int SIZE_W      = 12;
  localparam int LIMIT_W     = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_OUT_COL_LIMIT = 3'd2,
    REG_OUT_ROW_LIMIT = 3'd3
  } ds22_reg_t;

  // Per-channel sums of a horizontal pixel pair, as kept in the half-line store.
  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } ds22_sums_t;

  // Adds the channels of a left and a right pixel.
  function automatic ds22_sums_t pair_sums(input logic [PIXEL_W-1:0] left,
                                           input logic [PIXEL_W-1:0] right);
    ds22_sums_t s;
    s.r = {1'b0, left[23:16]} + {1'b0, right[23:16]};
    s.g = {1'b0, left[15:8]}  + {1'b0, right[15:8]};
    s.b = {1'b0, left[7:0]}   + {1'b0, right[7:0]};
    return s;
  endfunction

  // Mean of four pixels from two pair sums, rounded half up.
  function automatic logic [7:0] quad_mean(input logic [8:0] a, input logic [8:0] b);
    logic [9:0] s;
    s = {1'b0, a} + {1'b0, b} + 10'd2;
    return s[9:2];
  endfunction

endpackage

`default_nettype wire

### hdl/ds22_pixel_if.sv
// Request channel carrying source pixels.
`timescale 1ns / 1ps
`default_nettype none

interface ds22_pixel_if;
  import ds22_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

### hdl/ds22_result_if.sv
// Request channel carrying averaged pixels and their destination indexes.
`timescale 1ns / 1ps
`default_nettype none

interface ds22_result_if;
  import ds22_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_color;
  logic [INDEX_W-1:0] out_index;

  modport source (output valid, output out_color, output out_index, input ready);
  modport sink   (input valid, input out_color, input out_index, output ready);
endinterface

`default_nettype wire

### hdl/ds22_cfg_if.sv
// Register write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface ds22_cfg_if;
  import ds22_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/ds22_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ds22_ram #(
  parameter int WIDTH  = 27,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/ds22_scan.sv
// Raster position tracking, pair summing and half-line store access.
`timescale 1ns / 1ps
`default_nettype none

module ds22_scan import ds22_pkg::*; #(
  parameter int COL_W  = 12,
  parameter int ROW_W  = 12,
  parameter int ADDR_W = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  ds22_pixel_if.sink              pixel,
  input  wire logic [COL_W-1:0]   width,
  input  wire logic [ROW_W-1:0]   height,
  input  wire logic [LIMIT_W-1:0] col_limit,
  input  wire logic [LIMIT_W-1:0] row_limit,
  input  wire logic               stage_free,
  output      logic               wr_en,
  output      logic [ADDR_W-1:0]  wr_addr,
  output      ds22_sums_t         wr_data,
  output      logic               rd_en,
  output      logic [ADDR_W-1:0]  rd_addr,
  output      logic               hand_valid,
  output      logic [COL_W-2:0]   hand_col,
  output      logic [ROW_W-2:0]   hand_row,
  output      ds22_sums_t         hand_sums
);

  logic               accept;
  logic [COL_W-1:0]   column_count;
  logic [COL_W-1:0]   column_count_next;
  logic [ROW_W-1:0]   row_count;
  logic [ROW_W-1:0]   row_count_next;
  logic [PIXEL_W-1:0] held_pixel;
  logic [COL_W-2:0]   slot;
  logic [ROW_W-2:0]   out_row;
  logic               in_limits;
  ds22_sums_t         sums;
  logic [COL_W-1:0]   col_inc;
  logic [ROW_W-1:0]   row_inc;

  // A pixel is taken whenever the blend stage can take a possible result.
  assign pixel.ready = stage_free;
  assign accept      = pixel.valid && pixel.ready;

  assign slot      = column_count[COL_W-1:1];
  assign out_row   = row_count[ROW_W-1:1];
  assign sums      = pair_sums(held_pixel, pixel.pixel_color);
  assign in_limits = (int'(slot) < int'(col_limit)) && (int'(out_row) < int'(row_limit));

  // Even rows store pair sums; odd rows read them back for the finished block.
  assign wr_en   = accept && column_count[0] && !row_count[0];
  assign wr_addr = slot[ADDR_W-1:0];
  assign wr_data = sums;
  assign rd_en   = accept && column_count[0] && row_count[0] && in_limits;
  assign rd_addr = slot[ADDR_W-1:0];

  assign hand_valid = rd_en;
  assign hand_col   = slot;
  assign hand_row   = out_row;
  assign hand_sums  = sums;

  // Raster counters wrap at the configured size.
  assign col_inc = column_count + COL_W'(1);
  assign row_inc = row_count + ROW_W'(1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_inc >= width) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= height) ? '0 : row_inc;
    end else begin
      column_count_next = col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (!column_count[0]) begin
        held_pixel <= pixel.pixel_color;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ds22_blend.sv
// Combines stored and current pair sums, forms the index and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module ds22_blend import ds22_pkg::*; #(
  parameter int COL_W = 12,
  parameter int ROW_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  ds22_result_if.source         result,
  input  wire logic             hand_valid,
  input  wire logic [COL_W-2:0] hand_col,
  input  wire logic [ROW_W-2:0] hand_row,
  input  wire ds22_sums_t       hand_sums,
  input  wire ds22_sums_t       upper,
  input  wire logic [COL_W-1:0] width,
  output      logic             stage_free
);

  localparam int PROD_W = ROW_W - 1 + COL_W + 1;
  localparam int IDX_W  = (PROD_W > INDEX_W) ? PROD_W : INDEX_W;

  logic               s1_valid;
  logic [COL_W-2:0]   s1_col;
  logic [ROW_W-2:0]   s1_row;
  ds22_sums_t         s1_lower;
  logic               stage_move;
  logic               out_valid;
  logic [PIXEL_W-1:0] out_color;
  logic [INDEX_W-1:0] out_index;
  logic [PIXEL_W-1:0] color_next;
  logic [IDX_W-1:0]   index_full;

  // The stage moves on when the output register is empty or being emptied.
  assign stage_move = s1_valid && (!out_valid || result.ready);
  assign stage_free = !s1_valid || stage_move;

  // Stage one waits for the half-line store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hand_valid) begin
      s1_valid <= 1'b1;
    end else if (stage_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hand_valid) begin
      s1_col   <= hand_col;
      s1_row   <= hand_row;
      s1_lower <= hand_sums;
    end
  end

  // Block mean and destination index.
  assign color_next = {quad_mean(upper.r, s1_lower.r),
                       quad_mean(upper.g, s1_lower.g),
                       quad_mean(upper.b, s1_lower.b)};
  assign index_full = IDX_W'(s1_row) * IDX_W'(width) + IDX_W'(s1_col);

  // Output register parts the result channel from the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_color <= color_next;
      out_index <= index_full[INDEX_W-1:0];
    end
  end

  assign result.valid     = out_valid;
  assign result.out_color = out_color;
  assign result.out_index = out_index;

endmodule

`default_nettype wire

### hdl/downsample_2x2_average.sv
// Top level of the 2x2 box-filter downsampler.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packed RGB pixel per cycle in raster order, unless stalled, and returns
// the rounded mean of every 2x2 block that lies inside the output limits, with its
// destination index (output row times image width plus output column). An odd last
// column or row is dropped. A result passes stage one and the output register, and
// the pixel input stalls only while a result is held in the output register and
// another waits behind it. Pair sums of even rows live in a half-line RAM of
// (MAX_WIDTH+1)/2 words of 27 bits with one write and one registered read port;
// odd rows read them back a whole row later, so no read can meet a pending write.
// The RAM needs no clearing after reset. The user must write registers only while
// no pixel is in flight, not enforced by the block; unlisted indexes are ignored.
module downsample_2x2_average import ds22_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input wire logic   clk,
  input wire logic   rst,
  ds22_pixel_if.sink    pixel,
  ds22_result_if.source result,
  ds22_cfg_if.sink      cfg
);

  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [SIZE_W-1:0]  image_width;
  logic [SIZE_W-1:0]  image_height;
  logic [LIMIT_W-1:0] out_col_limit;
  logic [LIMIT_W-1:0] out_row_limit;
  logic [COL_W-1:0]   width_eff;
  logic [ROW_W-1:0]   height_eff;
  logic               stage_free;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  ds22_sums_t         wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  ds22_sums_t         rd_data;
  logic               hand_valid;
  logic [COL_W-2:0]   hand_col;
  logic [ROW_W-2:0]   hand_row;
  ds22_sums_t         hand_sums;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'd2048;
      image_height  <= 12'd2048;
      out_col_limit <= 11'd1024;
      out_row_limit <= 11'd1024;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:   image_width   <= cfg.data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg.data;
        REG_OUT_COL_LIMIT: out_col_limit <= cfg.data[LIMIT_W-1:0];
        REG_OUT_ROW_LIMIT: out_row_limit <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Image size clamped to the supported range.
  always_comb begin
    if (image_width < 12'd2) begin
      width_eff = COL_W'(2);
    end else if (int'(image_width) > MAX_WIDTH) begin
      width_eff = COL_W'(MAX_WIDTH);
    end else begin
      width_eff = COL_W'(image_width);
    end
  end

  always_comb begin
    if (image_height < 12'd2) begin
      height_eff = ROW_W'(2);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      height_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      height_eff = ROW_W'(image_height);
    end
  end

  ds22_scan #(
    .COL_W  (COL_W),
    .ROW_W  (ROW_W),
    .ADDR_W (ADDR_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .width      (width_eff),
    .height     (height_eff),
    .col_limit  (out_col_limit),
    .row_limit  (out_row_limit),
    .stage_free (stage_free),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .hand_valid (hand_valid),
    .hand_col   (hand_col),
    .hand_row   (hand_row),
    .hand_sums  (hand_sums)
  );

  ds22_ram #(
    .WIDTH  ($bits(ds22_sums_t)),
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ds22_blend #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .hand_valid (hand_valid),
    .hand_col   (hand_col),
    .hand_row   (hand_row),
    .hand_sums  (hand_sums),
    .upper      (rd_data),
    .width      (width_eff),
    .stage_free (stage_free)
  );

endmodule

`default_nettype wire

### hdl/ds22_checker.sv
// Port-level checks for the downsampler and their attachment to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ds22_checker import ds22_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               pix_valid,
  input wire logic               pix_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic [PIXEL_W-1:0] res_color,
  input wire logic [INDEX_W-1:0] res_index
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_color) && $stable(res_index))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  // A fresh result follows the request that completed its block.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
    else $error("result without a matching request");

  // The pixel input stalls only while the result channel is blocked.
  assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> res_valid && !res_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind downsample_2x2_average ds22_checker u_ds22_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixel.valid),
  .pix_ready (pixel.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_color (result.out_color),
  .res_index (result.out_index)
);

`default_nettype wire
